// ===== sv/mbws_pkg.sv =====
// shared constants and types for the max box window sum block
package mbws_pkg;

    localparam int MAX_SIDE    = 16;
    localparam int SIDE_W      = $clog2(MAX_SIDE);
    localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int CELL_W    = 5;
    localparam int COL_W     = 9;
    localparam int SUM_W     = 13;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0] GRID_SIDE_RESET   = 5'd16;
    localparam logic [CFG_W-1:0] WINDOW_SIDE_RESET = 5'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_SIDE   = 1'b0,
        REG_WINDOW_SIDE = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic last;
        logic col_first;
        logic use_old;
        logic drop_col;
        logic check;
    } t_cell_ctl;

endpackage

// ===== sv/mbws_cell_store.sv =====
// generic single write port, single registered read port ram
module mbws_cell_store #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 5
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/mbws_window.sv =====
// column sums, horizontal running sum and best total for one cell per cycle while i_fire is high
module mbws_window
    import mbws_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,
    input  logic              i_fire,
    input  t_cell_ctl         i_ctl,
    input  logic [CELL_W-1:0] i_cell,
    input  logic [CELL_W-1:0] i_old,
    input  logic [SIDE_W-1:0] i_col,
    input  logic [SIDE_W-1:0] i_tap,
    output logic [SUM_W-1:0]  o_best_next
);

    logic [COL_W-1:0] r_col_sum [MAX_SIDE];
    logic [COL_W-1:0] r_line    [MAX_SIDE];
    logic [SUM_W-1:0] r_row_sum;
    logic [SUM_W-1:0] r_best;

    logic [COL_W:0]   col_raw;
    logic [COL_W-1:0] col_new;
    logic [COL_W-1:0] drop;
    logic [SUM_W:0]   row_raw;
    logic [SUM_W-1:0] row_new;
    logic             clear;

    assign clear = i_clear || (i_fire && i_ctl.last);

    always_comb begin
        col_raw = {1'b0, r_col_sum[i_col]} + (COL_W+1)'(i_cell);
        if (i_ctl.use_old) begin
            col_raw = (col_raw >= (COL_W+1)'(i_old)) ? col_raw - (COL_W+1)'(i_old) : '0;
        end
        col_new = col_raw[COL_W-1:0];

        drop    = r_line[i_tap];
        row_raw = (i_ctl.col_first ? '0 : {1'b0, r_row_sum}) + (SUM_W+1)'(col_new);
        if (i_ctl.drop_col) begin
            row_raw = (row_raw >= (SUM_W+1)'(drop)) ? row_raw - (SUM_W+1)'(drop) : '0;
        end
        row_new = row_raw[SUM_W-1:0];

        o_best_next = (i_ctl.check && (row_new > r_best)) ? row_new : r_best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear) begin
            for (int i = 0; i < MAX_SIDE; i++) begin
                r_col_sum[i] <= '0;
            end
            r_row_sum <= '0;
            r_best    <= '0;
        end else if (i_fire) begin
            r_col_sum[i_col] <= col_new;
            r_row_sum        <= row_new;
            r_best           <= o_best_next;
        end
    end

    // recent column sums of this row, tap picks the one a window side back
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_line[0] <= col_new;
            for (int i = 1; i < MAX_SIDE; i++) begin
                r_line[i] <= r_line[i-1];
            end
        end
    end

endmodule

// ===== sv/max_box_window_sum.sv =====
// Takes one grid cell per transfer in raster order and, after the last cell of a
// grid, gives one transfer carrying the largest square window sum of that grid.
// A cell is taken every cycle unless the input stalls: the cell store read and
// the raster position are handled in the accept cycle, and the column, row and
// best sums are updated in the following stage, which also registers the result
// of a grid with its last cell. Input stalls only when a finished result
// still waits in the output register as the last cell of the next grid reaches the
// sum stage. Any configuration write restarts the grid; a window that does not fit
// gives zero.
module max_box_window_sum
    import mbws_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [CELL_W-1:0]    i_cell_value,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [SUM_W-1:0]     o_best_sum,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0]  r_grid;
    logic [CFG_W-1:0]  r_win;
    logic [SIDE_W-1:0] r_row;
    logic [SIDE_W-1:0] r_col;

    logic              r_s1_valid;
    logic [CELL_W-1:0] r_s1_cell;
    logic [SIDE_W-1:0] r_s1_col;
    t_cell_ctl         r_s1_ctl;

    logic              r_out_valid;
    logic [SUM_W-1:0]  r_best_sum;

    logic [SIDE_W-1:0] g_m1;
    logic [SIDE_W-1:0] tap;
    logic              active;
    logic              in_xfer;
    logic              s1_fire;
    t_cell_ctl         n_ctl;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [CELL_W-1:0] old_cell;
    logic [SUM_W-1:0]  best_next;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid <= GRID_SIDE_RESET;
            r_win  <= WINDOW_SIDE_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_GRID_SIDE:   r_grid <= i_cfg_data;
                REG_WINDOW_SIDE: r_win  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_grid == '0) begin
            g_m1 = '0;
        end else if (int'(r_grid) > MAX_SIDE) begin
            g_m1 = SIDE_W'(MAX_SIDE - 1);
        end else begin
            g_m1 = SIDE_W'(int'(r_grid) - 1);
        end
    end

    assign active = (r_win != '0) && (int'(r_win) <= int'(g_m1) + 1);
    assign tap    = SIDE_W'(int'(r_win) - 1);

    assign s1_fire    = r_s1_valid && (!r_s1_ctl.last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_comb begin
        n_ctl.last      = (r_col == g_m1) && (r_row == g_m1);
        n_ctl.col_first = (r_col == '0);
        n_ctl.use_old   = active && (int'(r_row) >= int'(r_win));
        n_ctl.drop_col  = int'(r_col) >= int'(r_win);
        n_ctl.check     = active && (int'(r_row) + 1 >= int'(r_win))
                                 && (int'(r_col) + 1 >= int'(r_win));
    end

    assign wr_addr = ADDR_W'(r_row) * ADDR_W'(MAX_SIDE) + ADDR_W'(r_col);
    assign rd_addr = ADDR_W'(SIDE_W'(int'(r_row) - int'(r_win))) * ADDR_W'(MAX_SIDE)
                   + ADDR_W'(r_col);

    // raster position of the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_row <= '0;
            r_col <= '0;
        end else if (in_xfer) begin
            if (r_col == g_m1) begin
                r_col <= '0;
                r_row <= (r_row == g_m1) ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_cell <= i_cell_value;
            r_s1_col  <= r_col;
            r_s1_ctl  <= n_ctl;
        end
    end

    mbws_cell_store #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (CELL_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (in_xfer),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_cell_value),
        .i_rd_en   (in_xfer),
        .i_rd_addr (rd_addr),
        .o_rd_data (old_cell)
    );

    mbws_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (i_cfg_we),
        .i_fire      (s1_fire),
        .i_ctl       (r_s1_ctl),
        .i_cell      (r_s1_cell),
        .i_old       (old_cell),
        .i_col       (r_s1_col),
        .i_tap       (tap),
        .o_best_next (best_next)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_ctl.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_ctl.last) begin
            r_best_sum <= best_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_best_sum  = r_best_sum;

`ifndef NO_ASSERTIONS
    a_stall_only_on_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_valid && r_s1_ctl.last && r_out_valid && !i_out_ready))
        else $error("input stalled without a pending result");

    a_last_cell_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_ctl.last) |=> o_out_valid)
        else $error("last cell of grid did not produce a result");

    a_position_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= g_m1) && (r_col <= g_m1))
        else $error("raster position outside grid");

    a_cfg_restarts_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> ((r_row == '0) && (r_col == '0) && !r_s1_valid))
        else $error("configuration write did not restart the grid");
`endif

endmodule
